// ----- hdl/assert_macros.svh -----
// Assertion macros for the RTL files of the three-axis controller.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Condition that must hold at every clock edge out of reset.
`define TPD_ASSERT_ALWAYS(name, cond, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error(msg);

// Same-cycle implication.
`define TPD_ASSERT_IMPL(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define TPD_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define TPD_ASSERT_ALWAYS(name, cond, msg)
`define TPD_ASSERT_IMPL(name, ante, cons, msg)
`define TPD_ASSERT_NEXT(name, ante, cons, msg)

`endif

`endif

// ----- hdl/tpd_pkg.sv -----
// Types, constants and helper functions of the three-axis PID controller.
package tpd_pkg;

	localparam int FRACTION_BITS = 16;

	localparam int NUM_AXES = 3;
	localparam int AXIS_W   = 2;
	localparam int GAIN_W   = 31;
	localparam int IDX_W    = 3;

	// product of a 33-bit signed operand and a 31-bit unsigned gain
	localparam int PROD_W = 65;
	localparam int SCL_W  = PROD_W - FRACTION_BITS;
	localparam int ACC_W  = SCL_W + 2;

	localparam longint unsigned ONE_FX = 64'd1 << FRACTION_BITS;
	localparam longint unsigned MASK31 = 64'h7FFF_FFFF;

	localparam logic [GAIN_W-1:0] KP_RST   = GAIN_W'((ONE_FX + 5) / 10);
	localparam logic [GAIN_W-1:0] KI_RST   = GAIN_W'((ONE_FX + 100) / 200);
	localparam logic [GAIN_W-1:0] KD_RST   = GAIN_W'((ONE_FX + 50) / 100);
	localparam logic [GAIN_W-1:0] DB_RST   = GAIN_W'((ONE_FX + 50) / 100);
	localparam logic [GAIN_W-1:0] DT_RST   = GAIN_W'((ONE_FX + 50) / 100);
	localparam logic [GAIN_W-1:0] RATE_RST = GAIN_W'((ONE_FX * 100) & MASK31);

	typedef enum logic [IDX_W-1:0] {
		REG_KP   = 3'd0,
		REG_KI   = 3'd1,
		REG_KD   = 3'd2,
		REG_DB   = 3'd3,
		REG_DT   = 3'd4,
		REG_RATE = 3'd5
	} tpd_reg_t;

	typedef struct packed {
		logic signed [31:0] target_x;
		logic signed [31:0] target_y;
		logic signed [31:0] target_z;
		logic signed [31:0] measured_x;
		logic signed [31:0] measured_y;
		logic signed [31:0] measured_z;
	} tpd_in_t;

	typedef struct packed {
		logic signed [31:0] drive_x;
		logic signed [31:0] drive_y;
		logic signed [31:0] drive_z;
		logic signed [31:0] error_x_out;
		logic signed [31:0] error_y_out;
		logic signed [31:0] error_z_out;
	} tpd_out_t;

	typedef struct packed {
		logic [GAIN_W-1:0] kp;
		logic [GAIN_W-1:0] ki;
		logic [GAIN_W-1:0] kd;
		logic [GAIN_W-1:0] db;
		logic [GAIN_W-1:0] dt;
		logic [GAIN_W-1:0] rate;
	} tpd_cfg_t;

	// datapath step issued by the controller
	typedef enum logic [2:0] {
		OP_NONE  = 3'd0,
		OP_ERR   = 3'd1,
		OP_MDT   = 3'd2,
		OP_MRATE = 3'd3,
		OP_MP    = 3'd4,
		OP_MI    = 3'd5,
		OP_MD    = 3'd6,
		OP_FIN   = 3'd7
	} tpd_op_t;

	typedef struct packed {
		logic              take;
		logic              load;
		tpd_op_t           op;
		logic [AXIS_W-1:0] axis;
	} tpd_cmd_t;

	function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
		logic hi_any;
		logic hi_all;
		hi_any = |v[ACC_W-2:31];
		hi_all = &v[ACC_W-2:31];
		if (!v[ACC_W-1] && hi_any)
			return 32'sh7FFF_FFFF;
		else if (v[ACC_W-1] && !hi_all)
			return 32'sh8000_0000;
		else
			return v[31:0];
	endfunction

	function automatic logic signed [ACC_W-1:0] ext_w33(input logic signed [32:0] v);
		return {{(ACC_W-33){v[32]}}, v};
	endfunction

	function automatic logic signed [ACC_W-1:0] ext_scl(input logic signed [SCL_W-1:0] v);
		return {{(ACC_W-SCL_W){v[SCL_W-1]}}, v};
	endfunction

endpackage

// ----- hdl/three_axis_pid_deadband.sv -----
// Top level of the three-axis PID controller with integral deadband.
// Usage notes:
//  - sample channel (sample_valid / sample_stall / sample): one request holds
//    target and measured positions for x, y and z, signed Q16.16. A request
//    is taken on a clock edge with sample_valid high and sample_stall low.
//  - result channel (result_valid / result_stall / result): drive and error
//    per axis, signed Q16.16, taken on an edge with result_valid high and
//    result_stall low. Exactly one result per request, in order.
//  - cfg channel (cfg_valid / cfg_ready / cfg_index / cfg_data): writes the
//    six gain/timing registers; cfg_ready is always high, indexes 6 and 7
//    are dropped, bit 31 of the data is ignored. Write only while idle.
//  - Sequence: each axis passes through one 33x32 shared multiplier in the
//    steps error, dt, rate, kp, ki, kd and finish; the three axes run in
//    turn, then the result register is loaded. A new request is not taken
//    until the previous item has finished all three axes and its result has
//    been loaded into the result register.
//  - Back pressure: while the result register is still full and stalled,
//    the finished item waits in its final step and sample_stall stays high;
//    a new request is taken once the previous result has moved on.
//  - Reset (arst_n low): registers return to their defaults, integrals and
//    previous errors clear to zero, result_valid drops.
module three_axis_pid_deadband (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      sample_valid,
	output logic                      sample_stall,
	input  tpd_pkg::tpd_in_t          sample,
	output logic                      result_valid,
	input  logic                      result_stall,
	output tpd_pkg::tpd_out_t         result,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [tpd_pkg::IDX_W-1:0] cfg_index,
	input  logic [31:0]               cfg_data
);
	import tpd_pkg::*;

	tpd_cfg_t cfg;   // current register contents
	tpd_cmd_t cmd;   // per-cycle step from sequencer to datapath

	tpd_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// sequencer: request handshake, axis walk, result valid
	tpd_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.cmd          (cmd)
	);

	// arithmetic and kept per-axis state
	tpd_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.cfg    (cfg),
		.sample (sample),
		.result (result)
	);

endmodule

// ----- hdl/tpd_regs.sv -----
// Configuration register file: gains, deadband, step time and step rate.
module tpd_regs (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [tpd_pkg::IDX_W-1:0]  cfg_index,
	input  logic [31:0]             cfg_data,
	output tpd_pkg::tpd_cfg_t       cfg
);
	import tpd_pkg::*;

	tpd_cfg_t          cfg_q;
	logic [GAIN_W-1:0] wdata;

	assign cfg_ready = 1'b1;
	assign wdata     = cfg_data[GAIN_W-1:0];
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.kp   <= KP_RST;
			cfg_q.ki   <= KI_RST;
			cfg_q.kd   <= KD_RST;
			cfg_q.db   <= DB_RST;
			cfg_q.dt   <= DT_RST;
			cfg_q.rate <= RATE_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_KP:   cfg_q.kp   <= wdata;
				REG_KI:   cfg_q.ki   <= wdata;
				REG_KD:   cfg_q.kd   <= wdata;
				REG_DB:   cfg_q.db   <= wdata;
				REG_DT:   cfg_q.dt   <= wdata;
				REG_RATE: cfg_q.rate <= wdata;
				default: ;
			endcase
		end
	end

endmodule

// ----- hdl/tpd_ctrl.sv -----
// Sequencer: walks each axis through the shared-multiplier steps.
`include "assert_macros.svh"

module tpd_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              sample_valid,
	output logic              sample_stall,
	output logic              result_valid,
	input  logic              result_stall,
	output tpd_pkg::tpd_cmd_t cmd
);
	import tpd_pkg::*;

	typedef enum logic [8:0] {
		S_IDLE  = 9'b000000001,
		S_ERR   = 9'b000000010,
		S_MDT   = 9'b000000100,
		S_MRATE = 9'b000001000,
		S_MP    = 9'b000010000,
		S_MI    = 9'b000100000,
		S_MD    = 9'b001000000,
		S_FIN   = 9'b010000000,
		S_DONE  = 9'b100000000
	} tpd_state_t;

	localparam logic [AXIS_W-1:0] LAST_AXIS = AXIS_W'(NUM_AXES - 1);

	tpd_state_t        state_q, state_d;
	logic [AXIS_W-1:0] axis_q;
	logic              res_valid_q;
	logic              take;
	logic              load;

	assign take         = (state_q == S_IDLE) && sample_valid;
	assign load         = (state_q == S_DONE) && (!res_valid_q || !result_stall);
	assign sample_stall = (state_q != S_IDLE);
	assign result_valid = res_valid_q;

	always_comb begin
		state_d  = state_q;
		cmd.take = take;
		cmd.load = load;
		cmd.axis = axis_q;
		cmd.op   = OP_NONE;
		unique case (state_q)
			S_IDLE:  if (sample_valid) state_d = S_ERR;
			S_ERR: begin
				cmd.op  = OP_ERR;
				state_d = S_MDT;
			end
			S_MDT: begin
				cmd.op  = OP_MDT;
				state_d = S_MRATE;
			end
			S_MRATE: begin
				cmd.op  = OP_MRATE;
				state_d = S_MP;
			end
			S_MP: begin
				cmd.op  = OP_MP;
				state_d = S_MI;
			end
			S_MI: begin
				cmd.op  = OP_MI;
				state_d = S_MD;
			end
			S_MD: begin
				cmd.op  = OP_MD;
				state_d = S_FIN;
			end
			S_FIN: begin
				cmd.op  = OP_FIN;
				state_d = (axis_q == LAST_AXIS) ? S_DONE : S_ERR;
			end
			S_DONE:  if (load) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			axis_q      <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_FIN)
				axis_q <= (axis_q == LAST_AXIS) ? '0 : axis_q + 1'b1;
			if (load)
				res_valid_q <= 1'b1;
			else if (!result_stall)
				res_valid_q <= 1'b0;
		end
	end

	`TPD_ASSERT_ALWAYS(a_axis_range, axis_q <= LAST_AXIS, "axis counter out of range")
	`TPD_ASSERT_NEXT(a_take_starts, take, state_q == S_ERR && axis_q == '0,
		"accepted request did not start at first axis")
	`TPD_ASSERT_NEXT(a_last_axis_done, state_q == S_FIN && axis_q == LAST_AXIS,
		state_q == S_DONE, "last axis did not finish the item")
	`TPD_ASSERT_NEXT(a_load_shows, load, res_valid_q && state_q == S_IDLE,
		"loaded result not presented")
	`TPD_ASSERT_IMPL(a_busy_no_take, state_q != S_IDLE, !cmd.take,
		"request taken while busy")

endmodule

// ----- hdl/tpd_dp.sv -----
// Datapath: error, shared multiplier, integral and previous-error state, result register.
module tpd_dp (
	input  logic              clk,
	input  logic              arst_n,
	input  tpd_pkg::tpd_cmd_t cmd,
	input  tpd_pkg::tpd_cfg_t cfg,
	input  tpd_pkg::tpd_in_t  sample,
	output tpd_pkg::tpd_out_t result
);
	import tpd_pkg::*;

	tpd_in_t                   item_q;
	tpd_out_t                  result_q;
	logic signed [31:0]        integ_q [NUM_AXES];
	logic signed [31:0]        prev_q  [NUM_AXES];
	logic signed [31:0]        drv_q   [NUM_AXES];
	logic signed [31:0]        err_q   [NUM_AXES];
	logic signed [31:0]        e_q;
	logic signed [31:0]        deriv_q;
	logic signed [ACC_W-1:0]   acc_q;
	logic signed [PROD_W-1:0]  prod_q;

	logic signed [31:0]        tgt;
	logic signed [31:0]        meas;
	logic signed [32:0]        diff_in;
	logic signed [32:0]        diff_e;
	logic [32:0]               mag;
	logic                      integrate;
	logic signed [SCL_W-1:0]   scaled;
	logic signed [32:0]        mul_a;
	logic [GAIN_W-1:0]         mul_b;
	logic signed [PROD_W-1:0]  prod_d;
	logic signed [31:0]        integ_cur;
	logic signed [31:0]        integ_new;
	logic signed [ACC_W-1:0]   acc_sum;

	assign result = result_q;

	always_comb begin
		case (cmd.axis)
			2'd0:    begin tgt = item_q.target_x; meas = item_q.measured_x; end
			2'd1:    begin tgt = item_q.target_y; meas = item_q.measured_y; end
			default: begin tgt = item_q.target_z; meas = item_q.measured_z; end
		endcase
	end

	assign diff_in   = {tgt[31], tgt} - {meas[31], meas};
	assign integ_cur = integ_q[cmd.axis];
	assign diff_e    = {e_q[31], e_q} - {prev_q[cmd.axis][31], prev_q[cmd.axis]};
	assign mag       = e_q[31] ? -{e_q[31], e_q} : {e_q[31], e_q};
	assign integrate = mag > {2'b00, cfg.db};

	// floor(product / 2^F)
	assign scaled    = prod_q[PROD_W-1:FRACTION_BITS];
	assign integ_new = sat32(ext_w33({integ_cur[31], integ_cur}) + ext_scl(scaled));
	assign acc_sum   = acc_q + ext_scl(scaled);

	always_comb begin
		mul_a = {e_q[31], e_q};
		mul_b = cfg.kp;
		unique case (cmd.op)
			OP_MDT:   mul_b = cfg.dt;
			OP_MRATE: begin mul_a = diff_e; mul_b = cfg.rate; end
			OP_MI:    begin mul_a = {integ_cur[31], integ_cur}; mul_b = cfg.ki; end
			OP_MD:    begin mul_a = {deriv_q[31], deriv_q}; mul_b = cfg.kd; end
			default: ;
		endcase
	end

	assign prod_d = mul_a * $signed({1'b0, mul_b});

	// kept state per axis
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_AXES; i++) begin
				integ_q[i] <= '0;
				prev_q[i]  <= '0;
			end
		end else begin
			if (cmd.op == OP_MRATE && integrate)
				integ_q[cmd.axis] <= integ_new;
			if (cmd.op == OP_FIN)
				prev_q[cmd.axis] <= e_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take)
			item_q <= sample;
		prod_q <= prod_d;
		unique case (cmd.op)
			OP_ERR: e_q     <= sat32(ext_w33(diff_in));
			OP_MP:  deriv_q <= sat32(ext_scl(scaled));
			OP_MI:  acc_q   <= ext_scl(scaled);
			OP_MD:  acc_q   <= acc_sum;
			OP_FIN: begin
				drv_q[cmd.axis] <= sat32(acc_sum);
				err_q[cmd.axis] <= e_q;
			end
			default: ;
		endcase
		if (cmd.load) begin
			result_q.drive_x     <= drv_q[0];
			result_q.drive_y     <= drv_q[1];
			result_q.drive_z     <= drv_q[2];
			result_q.error_x_out <= err_q[0];
			result_q.error_y_out <= err_q[1];
			result_q.error_z_out <= err_q[2];
		end
	end

endmodule
